[rtl/core/ftrl_pkg.sv]
// ----------------------------------------------------------------------------
// ftrl_pkg
// Shared constants and types of the FTRL-proximal row update unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ftrl_pkg;

  localparam int unsigned RowDim    = 16;
  localparam int unsigned AddrW     = (RowDim > 1) ? $clog2(RowDim) : 1;
  localparam int unsigned IdxW      = 4;
  localparam int unsigned DataW     = 32;
  localparam int unsigned NW        = 40;
  localparam int unsigned ShowW     = 16;
  localparam int unsigned FracW     = 24;
  localparam int unsigned DivW      = NW + 1;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = FifoPtrW + 1;
  localparam int unsigned SqrtLat   = DataW;
  localparam int unsigned DivLat    = DataW + 1;
  localparam int unsigned PaddrW    = 4;

  localparam logic [DataW-1:0] RateRst = 32'd838861;
  localparam logic [DataW-1:0] L1Rst   = 32'd0;
  localparam logic [DataW-1:0] L2Rst   = 32'd0;
  localparam logic [DataW-1:0] BetaRst = 32'd16777216;

  typedef enum logic [1:0] {
    CfgRate = 2'd0,
    CfgL1   = 2'd1,
    CfgL2   = 2'd2,
    CfgBeta = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [DataW-1:0] rate;
    logic [DataW-1:0] l1;
    logic [DataW-1:0] l2;
    logic [DataW-1:0] beta;
  } cfg_t;

  typedef struct packed {
    logic [IdxW-1:0]  idx;
    logic [DataW-1:0] grad;
    logic             oor;
  } q_item_t;

endpackage

`default_nettype wire

[rtl/core/ftrl_if.sv]
// ----------------------------------------------------------------------------
// ftrl_if
// Valid/ready channels for gradient items and weight results.
// ----------------------------------------------------------------------------
`default_nettype none

interface ftrl_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  elem_index;
  logic [31:0] gradient;
  logic [15:0] show_incr;

  modport source (output valid, elem_index, gradient, show_incr, input ready);
  modport sink   (input valid, elem_index, gradient, show_incr, output ready);
endinterface

interface ftrl_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  out_index;
  logic [31:0] new_weight;

  modport source (output valid, out_index, new_weight, input ready);
  modport sink   (input valid, out_index, new_weight, output ready);
endinterface

`default_nettype wire

[rtl/core/ftrl_proximal_update_unit.sv]
// ----------------------------------------------------------------------------
// ftrl_proximal_update_unit
// FTRL-proximal update of one embedding row, one element per transaction.
//
//   channel  | dir | handshake      | payload
//   in_ch    | in  | valid/ready    | elem_index, gradient, show_incr
//   out_ch   | out | valid/ready    | out_index, new_weight
//   apb      | in  | psel/penable   | paddr, pwdata, prdata (rate, l1, l2, beta)
//
// one transaction per cycle while no element repeats within the pipeline depth and the output is not stalled
// from input to result an item passes the queue, the 32-stage square roots,
// the 33-stage divider and the multiply stages
// an item whose element is still in the pipeline waits at the queue head
// until that element is written back (per-element read-modify-write loop)
// reset clears all stores at once; an output stall freezes the pipeline
// while the 4-entry queue keeps taking transactions
// ----------------------------------------------------------------------------
`default_nettype none

module ftrl_proximal_update_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  ftrl_in_if.sink                     in_ch,
  ftrl_out_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ftrl_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import ftrl_pkg::*;

  cfg_t     cfg_q;
  q_item_t  head;
  logic     head_valid, pop;
  cfg_reg_e reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rate <= RateRst;
      cfg_q.l1   <= L1Rst;
      cfg_q.l2   <= L2Rst;
      cfg_q.beta <= BetaRst;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        CfgRate: cfg_q.rate <= pwdata;
        CfgL1:   cfg_q.l1   <= pwdata;
        CfgL2:   cfg_q.l2   <= pwdata;
        CfgBeta: cfg_q.beta <= pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      CfgRate: prdata = cfg_q.rate;
      CfgL1:   prdata = cfg_q.l1;
      CfgL2:   prdata = cfg_q.l2;
      CfgBeta: prdata = cfg_q.beta;
    endcase
  end

  ftrl_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_ch        (in_ch),
    .head_o       (head),
    .head_valid_o (head_valid),
    .pop_i        (pop)
  );

  ftrl_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_i       (head),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .out_ch       (out_ch)
  );

endmodule

`default_nettype wire

[rtl/core/ftrl_front.sv]
// ----------------------------------------------------------------------------
// ftrl_front
// Accepts gradient transactions, classifies the index, keeps the show
// counter and queues items for the update pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module ftrl_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  ftrl_in_if.sink           in_ch,
  output ftrl_pkg::q_item_t head_o,
  output logic              head_valid_o,
  input  logic              pop_i
);
  import ftrl_pkg::*;

  q_item_t               fifo_q [FifoDepth];
  logic [FifoPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0]   count_q, count_d;
  logic [DataW-1:0]      show_q;
  logic [DataW:0]        show_sum;
  logic                  push, pop;
  q_item_t               new_item;

  assign in_ch.ready  = (count_q != FifoCntW'(FifoDepth));
  assign push         = in_ch.valid && in_ch.ready;
  assign head_valid_o = (count_q != '0);
  assign pop          = pop_i && head_valid_o;
  assign head_o       = fifo_q[rd_ptr_q];

  always_comb begin
    new_item.idx  = in_ch.elem_index;
    new_item.grad = in_ch.gradient;
    new_item.oor  = (32'(in_ch.elem_index) >= RowDim);
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
    show_sum = {1'b0, show_q} + {{(DataW + 1 - ShowW){1'b0}}, in_ch.show_incr};
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= new_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
      show_q   <= '0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      // show counter on element 0, saturating
      if (push && in_ch.elem_index == '0) begin
        show_q <= show_sum[DataW] ? '1 : show_sum[DataW-1:0];
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/ftrl_sqrt.sv]
// ----------------------------------------------------------------------------
// ftrl_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ftrl_sqrt (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [2*ftrl_pkg::DataW-1:0] x_i,
  output logic [ftrl_pkg::DataW-1:0]   root_o
);
  import ftrl_pkg::*;

  localparam int unsigned XW   = 2 * DataW;
  localparam int unsigned RemW = DataW + 2;
  localparam int unsigned CurW = RemW + 2;

  logic [RemW-1:0]  rem_q  [SqrtLat];
  logic [DataW-1:0] root_q [SqrtLat];
  logic [XW-1:0]    x_q    [SqrtLat];

  for (genvar k = 0; k < SqrtLat; k++) begin : g_stage
    localparam int unsigned B = SqrtLat - 1 - k;
    logic [RemW-1:0]  rem_in;
    logic [DataW-1:0] root_in;
    logic [XW-1:0]    x_in;
    logic [CurW-1:0]  cur, trial;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = x_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign x_in    = x_q[k-1];
    end

    assign cur   = {rem_in, x_in[2*B+1 -: 2]};
    assign trial = {2'b00, root_in, 2'b01};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[k] <= x_in;
        if (cur >= trial) begin
          rem_q[k]  <= RemW'(cur - trial);
          root_q[k] <= {root_in[DataW-2:0], 1'b1};
        end else begin
          rem_q[k]  <= cur[RemW-1:0];
          root_q[k] <= {root_in[DataW-2:0], 1'b0};
        end
      end
    end
  end

  assign root_o = root_q[SqrtLat-1];

endmodule

`default_nettype wire

[rtl/core/ftrl_div.sv]
// ----------------------------------------------------------------------------
// ftrl_div
// Pipelined restoring divider for the weight magnitude, clamped at 2^31.
// ----------------------------------------------------------------------------
`default_nettype none

module ftrl_div (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [ftrl_pkg::DataW-1:0] numer_i,
  input  logic [ftrl_pkg::DivW-1:0]  divisor_i,
  output logic [ftrl_pkg::DataW-1:0] mag_o
);
  import ftrl_pkg::*;

  localparam int unsigned NumW = DataW + FracW;
  localparam int unsigned CmpW = DivW + DataW;
  localparam logic [DataW-1:0] MagMax = {1'b1, {(DataW-1){1'b0}}};

  logic [NumW-1:0]  rem_q [DivLat];
  logic [DivW-1:0]  d_q   [DivLat];
  logic [DataW-1:0] q_q   [DivLat];
  logic             sat_q [DivLat];

  logic [NumW-1:0] n0;
  assign n0 = {numer_i, {FracW{1'b0}}};

  // overflow check: quotient would reach 2^32, or zero divisor
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= n0;
      d_q[0]   <= divisor_i;
      q_q[0]   <= '0;
      sat_q[0] <= (divisor_i == '0) ||
                  ({{(CmpW-NumW){1'b0}}, n0} >= {divisor_i, {DataW{1'b0}}});
    end
  end

  for (genvar k = 1; k < DivLat; k++) begin : g_stage
    localparam int unsigned B = DivLat - 1 - k;
    logic [CmpW-1:0] shifted;
    logic            take;

    assign shifted = CmpW'(d_q[k-1]) << B;
    assign take    = !sat_q[k-1] && ({{(CmpW-NumW){1'b0}}, rem_q[k-1]} >= shifted);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        d_q[k]   <= d_q[k-1];
        sat_q[k] <= sat_q[k-1];
        if (take) begin
          rem_q[k]  <= rem_q[k-1] - shifted[NumW-1:0];
          q_q[k]    <= q_q[k-1] | (DataW'(1) << B);
        end else begin
          rem_q[k]  <= rem_q[k-1];
          q_q[k]    <= q_q[k-1];
        end
      end
    end
  end

  assign mag_o = (sat_q[DivLat-1] || q_q[DivLat-1] > MagMax) ? MagMax : q_q[DivLat-1];

endmodule

`default_nettype wire

[rtl/core/ftrl_back.sv]
// ----------------------------------------------------------------------------
// ftrl_back
// Update pipeline: accumulator read, n and z update through the square
// root units, weight division and write-back, with per-element busy bits.
// ----------------------------------------------------------------------------
`default_nettype none

module ftrl_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ftrl_pkg::cfg_t    cfg_i,
  input  ftrl_pkg::q_item_t head_i,
  input  logic              head_valid_i,
  output logic              pop_o,
  ftrl_out_if.source        out_ch
);
  import ftrl_pkg::*;

  localparam int unsigned TotalLat = 6 + SqrtLat + DivLat;
  localparam int unsigned ZW = DataW + 10;

  typedef struct packed {
    logic             valid;
    logic             oor;
    logic [IdxW-1:0]  idx;
    logic [DataW-1:0] g;
    logic [DataW-1:0] z;
    logic [DataW-1:0] w;
  } item_t;

  typedef struct packed {
    logic            valid;
    logic            oor;
    logic [IdxW-1:0] idx;
    logic            zero;
    logic            zpos;
  } dv_item_t;

  logic [DataW-1:0] weights_q [RowDim];
  logic [DataW-1:0] z_accum_q [RowDim];
  logic [NW-1:0]    n_accum_q [RowDim];
  logic [RowDim-1:0] busy_q, busy_d;

  item_t            s1_q, s1_d, s2_q, s3_q, s5_q, s6_q, s7_q, s7_d;
  item_t            sq_q [SqrtLat];
  dv_item_t         dv_q [DivLat];
  dv_item_t         dv_d, dv_last;
  logic [NW-1:0]    n1_q, n2_q, g2_q, nold3_q, nnew3_q, n_new_d;
  logic [DataW-1:0] s_old, s_new, p5_q, sum5_q, p_d, sum_d, zn_d, numer, zmag, mag;
  logic [NW-1:0]    tm6_q, srate6_q;
  logic             wneg6_q;
  logic [DivW-1:0]  div7_q, div_d;
  logic [DataW-1:0] gm, wm, wn;
  logic [2*DataW-1:0] g2_prod, p_prod, tm_prod, sr_prod;
  logic [NW:0]      n_sum;
  logic [DataW:0]   sum_b;
  logic [ZW-1:0]    zw, term;
  logic [AddrW-1:0] head_addr, a2, a6, aout;
  logic             adv, out_v_q, out_load;
  logic [IdxW-1:0]  out_idx_q;
  logic [DataW-1:0] out_w_q;

  assign adv       = !out_v_q || out_ch.ready;
  assign head_addr = AddrW'(head_i.idx);
  assign pop_o     = adv && head_valid_i && (head_i.oor || !busy_q[head_addr]);
  assign dv_last   = dv_q[DivLat-1];
  assign out_load  = adv && dv_last.valid;
  assign a2        = AddrW'(s2_q.idx);
  assign a6        = AddrW'(s6_q.idx);
  assign aout      = AddrW'(dv_last.idx);

  ftrl_sqrt u_sqrt_old (
    .clk_i  (clk_i),
    .en_i   (adv),
    .x_i    ({nold3_q, {FracW{1'b0}}}),
    .root_o (s_old)
  );

  ftrl_sqrt u_sqrt_new (
    .clk_i  (clk_i),
    .en_i   (adv),
    .x_i    ({nnew3_q, {FracW{1'b0}}}),
    .root_o (s_new)
  );

  ftrl_div u_div (
    .clk_i     (clk_i),
    .en_i      (adv),
    .numer_i   (numer),
    .divisor_i (div7_q),
    .mag_o     (mag)
  );

  always_comb begin
    s1_d.valid = pop_o;
    s1_d.oor   = head_i.oor;
    s1_d.idx   = head_i.idx;
    s1_d.g     = head_i.grad;
    s1_d.z     = z_accum_q[head_addr];
    s1_d.w     = weights_q[head_addr];

    gm      = s1_q.g[DataW-1] ? (~s1_q.g + 1'b1) : s1_q.g;
    g2_prod = gm * gm;

    n_sum   = {1'b0, n2_q} + {1'b0, g2_q};
    n_new_d = n_sum[NW] ? '1 : n_sum[NW-1:0];

    p_prod = cfg_i.rate * (s_new - s_old);
    p_d    = (|p_prod[2*DataW-1:DataW+FracW]) ? '1 : p_prod[DataW+FracW-1:FracW];
    sum_b  = {1'b0, cfg_i.beta} + {1'b0, s_new};
    sum_d  = sum_b[DataW] ? '1 : sum_b[DataW-1:0];

    wm      = s5_q.w[DataW-1] ? (~s5_q.w + 1'b1) : s5_q.w;
    tm_prod = p5_q * wm;
    sr_prod = sum5_q * cfg_i.rate;

    // z + g - term, then saturate to 32 bits
    term = wneg6_q ? (~{2'b00, tm6_q} + 1'b1) : {2'b00, tm6_q};
    zw   = {{(ZW-DataW){s6_q.z[DataW-1]}}, s6_q.z} +
           {{(ZW-DataW){s6_q.g[DataW-1]}}, s6_q.g} - term;
    if (!zw[ZW-1] && (|zw[ZW-2:DataW-1])) begin
      zn_d = {1'b0, {(DataW-1){1'b1}}};
    end else if (zw[ZW-1] && !(&zw[ZW-2:DataW-1])) begin
      zn_d = {1'b1, {(DataW-1){1'b0}}};
    end else begin
      zn_d = zw[DataW-1:0];
    end
    div_d = {1'b0, srate6_q} + {{(DivW-DataW){1'b0}}, cfg_i.l2};

    s7_d   = s6_q;
    s7_d.z = zn_d;

    zmag       = s7_q.z[DataW-1] ? (~s7_q.z + 1'b1) : s7_q.z;
    numer      = zmag - cfg_i.l1;
    dv_d.valid = s7_q.valid;
    dv_d.oor   = s7_q.oor;
    dv_d.idx   = s7_q.idx;
    dv_d.zero  = (zmag <= cfg_i.l1);
    dv_d.zpos  = !s7_q.z[DataW-1];

    if (dv_last.oor || dv_last.zero) begin
      wn = '0;
    end else if (dv_last.zpos) begin
      wn = ~mag + 1'b1;
    end else begin
      wn = mag[DataW-1] ? {1'b0, {(DataW-1){1'b1}}} : mag;
    end

    busy_d = busy_q;
    if (out_load && !dv_last.oor) begin
      busy_d[aout] = 1'b0;
    end
    if (pop_o && !head_i.oor) begin
      busy_d[head_addr] = 1'b1;
    end
  end

  // payload stages
  always_ff @(posedge clk_i) begin
    if (adv) begin
      n1_q     <= n_accum_q[head_addr];
      n2_q     <= n1_q;
      g2_q     <= g2_prod[NW+FracW-1:FracW];
      nold3_q  <= n2_q;
      nnew3_q  <= n_new_d;
      p5_q     <= p_d;
      sum5_q   <= sum_d;
      tm6_q    <= tm_prod[NW+FracW-1:FracW];
      srate6_q <= sr_prod[NW+FracW-1:FracW];
      wneg6_q  <= s5_q.w[DataW-1];
      div7_q   <= div_d;
      if (dv_last.valid) begin
        out_idx_q <= dv_last.idx;
        out_w_q   <= wn;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q    <= '0;
      s2_q    <= '0;
      s3_q    <= '0;
      s5_q    <= '0;
      s6_q    <= '0;
      s7_q    <= '0;
      out_v_q <= 1'b0;
      busy_q  <= '0;
      for (int i = 0; i < SqrtLat; i++) begin
        sq_q[i] <= '0;
      end
      for (int i = 0; i < DivLat; i++) begin
        dv_q[i] <= '0;
      end
      for (int i = 0; i < RowDim; i++) begin
        weights_q[i] <= '0;
        z_accum_q[i] <= '0;
        n_accum_q[i] <= '0;
      end
    end else begin
      busy_q <= busy_d;
      if (adv) begin
        s1_q    <= s1_d;
        s2_q    <= s1_q;
        s3_q    <= s2_q;
        sq_q[0] <= s3_q;
        for (int i = 1; i < SqrtLat; i++) begin
          sq_q[i] <= sq_q[i-1];
        end
        s5_q    <= sq_q[SqrtLat-1];
        s6_q    <= s5_q;
        s7_q    <= s7_d;
        dv_q[0] <= dv_d;
        for (int i = 1; i < DivLat; i++) begin
          dv_q[i] <= dv_q[i-1];
        end
        out_v_q <= dv_last.valid;
        if (s2_q.valid && !s2_q.oor) begin
          n_accum_q[a2] <= n_new_d;
        end
        if (s6_q.valid && !s6_q.oor) begin
          z_accum_q[a6] <= zn_d;
        end
        if (dv_last.valid && !dv_last.oor) begin
          weights_q[aout] <= wn;
        end
      end
    end
  end

  assign out_ch.valid      = out_v_q;
  assign out_ch.out_index  = out_idx_q;
  assign out_ch.new_weight = out_w_q;

  a_busy_on_writeback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && !dv_last.oor) |-> busy_q[aout])
    else $error("write-back of an element that is not marked busy");

  a_busy_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(busy_q) <= TotalLat)
    else $error("more busy elements than pipeline stages");

  a_busy_set_on_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && !head_i.oor) |=> busy_q[$past(head_addr)])
    else $error("issued element not marked busy");

endmodule

`default_nettype wire
